// ===== rtl/vsp_pkg.sv =====
// ---------------------------------------------------------------------------
// vsp_pkg: shared types and constants for the axis velocity profiler
// Field widths, fixed-point constants, register codes and lane interfaces.
// ---------------------------------------------------------------------------
package vsp_pkg;

  localparam int AXES    = 3;
  localparam int NAX     = (AXES < 3) ? AXES : 3;
  localparam int ERR_W   = 20;
  localparam int STEP_W  = 22;
  localparam int GAIN_W  = 32;
  localparam int SPEED_W = 20;
  localparam int REACH_W = 19;
  localparam int CFG_W   = 32;
  localparam int PROD_W  = ERR_W + GAIN_W;
  localparam int TGT_W   = PROD_W - 16;

  localparam logic [SPEED_W-1:0] SPEED_FLOOR = 20'd1258;
  localparam logic [SPEED_W-1:0] STOP_SPEED  = 20'd1258;
  localparam logic [SPEED_W-1:0] OVERSPEED   = 20'd84;
  localparam logic [ERR_W-1:0]   LOW_ERROR   = 20'd20;
  localparam logic [2:0]         FINISH_MUL  = 3'd5;

  localparam logic [GAIN_W-1:0]  GAIN_X_RST         = 32'd36650352;
  localparam logic [GAIN_W-1:0]  GAIN_Y_RST         = 32'd43980465;
  localparam logic [GAIN_W-1:0]  GAIN_Z_RST         = 32'd73300;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_XY_RST = 20'd167772;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_Z_RST  = 20'd67109;
  localparam logic [SPEED_W-1:0] ACCEL_STEP_RST     = 20'd2517;
  localparam logic [REACH_W-1:0] REACH_ERROR_XY_RST = 19'd25;
  localparam logic [REACH_W-1:0] REACH_ERROR_Z_RST  = 19'd5000;

  typedef enum logic [2:0] {
    REG_GAIN_X,
    REG_GAIN_Y,
    REG_GAIN_Z,
    REG_SPEED_LIMIT_XY,
    REG_SPEED_LIMIT_Z,
    REG_ACCEL_STEP,
    REG_REACH_ERROR_XY,
    REG_REACH_ERROR_Z
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic tracked;
  } lane_ctl_t;

  typedef struct packed {
    logic                     done;
    logic signed [STEP_W-1:0] step;
  } lane_stat_t;

  typedef struct packed {
    logic advance;
    logic commit;
  } pipe_ctl_t;

endpackage

// ===== rtl/vsp_lane.sv =====
// ---------------------------------------------------------------------------
// vsp_lane: one axis of the profiler
// Registers |error| and gain*|error| >> 16, then runs the accelerate / brake /
// cruise decision against the stored speed, direction and reached flag.
// ---------------------------------------------------------------------------
module vsp_lane import vsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  lane_ctl_t                ctl,
  input  logic signed [ERR_W-1:0]  err,
  input  logic [GAIN_W-1:0]        gain,
  input  logic [SPEED_W-1:0]       limit,
  input  logic [SPEED_W-1:0]       accel,
  input  logic [REACH_W-1:0]       reach,
  output lane_stat_t               stat
);

  logic [ERR_W-1:0]   mag_in;
  logic [PROD_W-1:0]  prod_in;

  logic [ERR_W-1:0]   mag;
  logic               neg;
  logic               zero;
  logic [TGT_W-1:0]   tgt_raw;

  logic [SPEED_W-1:0] speed;
  logic [SPEED_W-1:0] speed_next;
  logic               dir;
  logic               dir_next;
  logic               reached;

  logic [TGT_W-1:0]   tgt_floor;
  logic [SPEED_W-1:0] tgt;
  logic               now_reached;
  logic               change;
  logic               idle;
  logic [SPEED_W-1:0] half;
  logic [SPEED_W:0]   sum_up;
  logic [SPEED_W-1:0] speed_dec;
  logic [SPEED_W:0]   step_mag;
  logic [STEP_W-1:0]  step_ext;
  logic [ERR_W+2:0]   fin_mag;

  assign mag_in  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign prod_in = PROD_W'(gain) * PROD_W'(mag_in);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag     <= mag_in;
      neg     <= err[ERR_W-1];
      zero    <= (err == '0);
      tgt_raw <= prod_in[PROD_W-1:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed   <= '0;
      dir     <= 1'b0;
      reached <= 1'b0;
    end else if (ctl.commit) begin
      speed   <= speed_next;
      dir     <= dir_next;
      reached <= now_reached;
    end
  end

  assign tgt_floor   = (tgt_raw < TGT_W'(SPEED_FLOOR)) ? TGT_W'(SPEED_FLOOR) : tgt_raw;
  assign tgt         = (tgt_floor > TGT_W'(limit)) ? limit : tgt_floor[SPEED_W-1:0];
  assign now_reached = (mag < ERR_W'(reach));
  assign change      = zero || (neg != dir);
  assign idle        = (speed == '0);
  assign dir_next    = (change && idle && !zero) ? neg : dir;
  assign half        = accel >> 1;
  assign sum_up      = {1'b0, speed} + {1'b0, accel};
  assign speed_dec   = speed - accel;

  always_comb begin
    speed_next = speed;
    step_mag   = '0;
    if (ctl.tracked && (idle || (speed < tgt && !change && !now_reached))) begin
      if (!(idle && mag < LOW_ERROR)) begin
        step_mag   = {1'b0, speed} + {1'b0, half};
        speed_next = (sum_up > {1'b0, tgt}) ? tgt : sum_up[SPEED_W-1:0];
      end
    end else if (!idle && (change || now_reached || !ctl.tracked ||
                           {1'b0, speed} >= ({1'b0, tgt} + {1'b0, OVERSPEED}))) begin
      if (speed > tgt && (speed - tgt) < accel && !change && !now_reached && ctl.tracked) begin
        speed_next = tgt;
        step_mag   = {1'b0, tgt};
      end else if (speed < accel) begin
        speed_next = '0;
        step_mag   = '0;
      end else begin
        speed_next = speed_dec;
        step_mag   = {1'b0, half} + {1'b0, speed_dec};
      end
    end else begin
      step_mag = {1'b0, speed};
    end
  end

  assign step_ext  = STEP_W'(step_mag);
  assign stat.step = dir_next ? $signed(step_ext) : -$signed(step_ext);

  assign fin_mag   = (ERR_W+3)'(mag) * (ERR_W+3)'(FINISH_MUL);
  assign stat.done = (fin_mag < (ERR_W+3)'(reach)) && (speed <= STOP_SPEED) && reached;

endmodule

// ===== rtl/vsp_merge.sv =====
// ---------------------------------------------------------------------------
// vsp_merge: finish test and output register
// Combines the lane results, decides hold or commit, and drives the
// result word with its valid/ready handshake.
// ---------------------------------------------------------------------------
module vsp_merge import vsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s1_valid,
  input  logic                     s1_reading_valid,
  input  logic                     s1_tracked,
  input  lane_stat_t               stat [3],
  input  logic                     out_ready,
  output pipe_ctl_t                pctl,
  output logic                     out_valid,
  output logic signed [STEP_W-1:0] step_x,
  output logic signed [STEP_W-1:0] step_y,
  output logic signed [STEP_W-1:0] step_z,
  output logic                     finished
);

  logic all_done;
  logic hold;

  assign all_done     = stat[0].done && stat[1].done && stat[2].done;
  assign hold         = !s1_reading_valid || (all_done && s1_tracked);
  assign pctl.advance = !out_valid || out_ready;
  assign pctl.commit  = s1_valid && pctl.advance && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pctl.advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pctl.advance && s1_valid) begin
      step_x   <= hold ? '0 : stat[0].step;
      step_y   <= hold ? '0 : stat[1].step;
      step_z   <= hold ? '0 : stat[2].step;
      finished <= s1_reading_valid && all_done && s1_tracked;
    end
  end

endmodule

// ===== rtl/visual_servo_axis_velocity_profiler_unit.sv =====
// ---------------------------------------------------------------------------
// visual_servo_axis_velocity_profiler_unit: per-axis speed profiler
// Turns one vision error reading into a signed displacement per axis.
//
//   channel   handshake             word
//   in        in_valid / in_ready   reading_valid, error_x/y/z, target_tracked
//   out       out_valid / out_ready step_x/y/z, finished
//   cfg       cfg_write             cfg_index, cfg_data
//
// The first stage registers |error| and the gain product in each lane;
// the second runs the lane update against the stored axis state and the
// finish test, and loads the output register. One word per cycle is
// sustained while out_ready is high.
// rst is synchronous and restores axis state and register defaults.
// A stalled output holds the second stage; the first fills only while empty.
// ---------------------------------------------------------------------------
module visual_servo_axis_velocity_profiler_unit import vsp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     reading_valid,
  input  logic signed [ERR_W-1:0]  error_x,
  input  logic signed [ERR_W-1:0]  error_y,
  input  logic signed [ERR_W-1:0]  error_z,
  input  logic                     target_tracked,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [STEP_W-1:0] step_x,
  output logic signed [STEP_W-1:0] step_y,
  output logic signed [STEP_W-1:0] step_z,
  output logic                     finished,
  input  logic                     cfg_write,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  logic [GAIN_W-1:0]  gain_x, gain_y, gain_z;
  logic [SPEED_W-1:0] speed_limit_xy, speed_limit_z, accel_step;
  logic [REACH_W-1:0] reach_error_xy, reach_error_z;

  logic               s1_valid;
  logic               s1_reading_valid;
  logic               s1_tracked;
  logic               load;
  pipe_ctl_t          pctl;
  lane_ctl_t          lctl;

  logic signed [ERR_W-1:0] err_arr  [3];
  logic [GAIN_W-1:0]       gain_arr [3];
  lane_stat_t              stat     [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x         <= GAIN_X_RST;
      gain_y         <= GAIN_Y_RST;
      gain_z         <= GAIN_Z_RST;
      speed_limit_xy <= SPEED_LIMIT_XY_RST;
      speed_limit_z  <= SPEED_LIMIT_Z_RST;
      accel_step     <= ACCEL_STEP_RST;
      reach_error_xy <= REACH_ERROR_XY_RST;
      reach_error_z  <= REACH_ERROR_Z_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_X:         gain_x         <= cfg_data;
        REG_GAIN_Y:         gain_y         <= cfg_data;
        REG_GAIN_Z:         gain_z         <= cfg_data;
        REG_SPEED_LIMIT_XY: speed_limit_xy <= cfg_data[SPEED_W-1:0];
        REG_SPEED_LIMIT_Z:  speed_limit_z  <= cfg_data[SPEED_W-1:0];
        REG_ACCEL_STEP:     accel_step     <= cfg_data[SPEED_W-1:0];
        REG_REACH_ERROR_XY: reach_error_xy <= cfg_data[REACH_W-1:0];
        REG_REACH_ERROR_Z:  reach_error_z  <= cfg_data[REACH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = pctl.advance || !s1_valid;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_reading_valid <= reading_valid;
      s1_tracked       <= target_tracked;
    end
  end

  assign lctl.load    = load;
  assign lctl.commit  = pctl.commit;
  assign lctl.tracked = s1_tracked;

  assign err_arr[0]  = error_x;
  assign err_arr[1]  = error_y;
  assign err_arr[2]  = error_z;
  assign gain_arr[0] = gain_x;
  assign gain_arr[1] = gain_y;
  assign gain_arr[2] = gain_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    if (i < NAX) begin : g_on
      vsp_lane u_lane (
        .clk   (clk),
        .rst   (rst),
        .ctl   (lctl),
        .err   (err_arr[i]),
        .gain  (gain_arr[i]),
        .limit ((i < 2) ? speed_limit_xy : speed_limit_z),
        .accel (accel_step),
        .reach ((i < 2) ? reach_error_xy : reach_error_z),
        .stat  (stat[i])
      );
    end else begin : g_off
      assign stat[i].done = 1'b1;
      assign stat[i].step = '0;
    end
  end

  vsp_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .s1_valid         (s1_valid),
    .s1_reading_valid (s1_reading_valid),
    .s1_tracked       (s1_tracked),
    .stat             (stat),
    .out_ready        (out_ready),
    .pctl             (pctl),
    .out_valid        (out_valid),
    .step_x           (step_x),
    .step_y           (step_y),
    .step_z           (step_z),
    .finished         (finished)
  );

  a_finish_no_motion: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> step_x == '0 && step_y == '0 && step_z == '0)
    else $error("finished word carries motion");

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both stages are held");

  a_commit_needs_word: assert property (@(posedge clk) disable iff (rst)
    pctl.commit |-> s1_valid && s1_reading_valid && pctl.advance)
    else $error("axis state updated without a valid reading moving out");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
